// File: design/aes128_pkg.sv
// Shared types, constants and round functions for the AES-128 encrypt core.
package aes128_pkg;

   localparam int ROUND_COUNT     = 10;
   localparam int CSR_INDEX_WIDTH = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } aes128_csr_index_type;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } aes128_req_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } aes128_rsp_type;

   // What moves from one round cell to the next: state and the round key it used.
   typedef struct packed {
      logic [127:0] state;
      logic [127:0] round_key;
   } aes128_stage_type;

   localparam logic [7:0] RCON [ROUND_COUNT] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes and ShiftRows; byte i is column i/4, row i%4, byte 0 in the top bits.
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(c*4+r) -: 8] = SBOX[s[127-8*(((c+r)%4)*4+r) -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] t);
      logic [127:0] m;
      logic [7:0]   a0, a1, a2, a3, all;
      m = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = t[127-8*(c*4)   -: 8];
         a1  = t[127-8*(c*4+1) -: 8];
         a2  = t[127-8*(c*4+2) -: 8];
         a3  = t[127-8*(c*4+3) -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[127-8*(c*4)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         m[127-8*(c*4+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         m[127-8*(c*4+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         m[127-8*(c*4+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return m;
   endfunction

   // One step of the key schedule: four words from the previous round key.
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] tw, n0, n1, n2, n3;
      tw = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      n0 = k[127:96] ^ tw;
      n1 = k[95:64]  ^ n0;
      n2 = k[63:32]  ^ n1;
      n3 = k[31:0]   ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

// File: design/aes128_block_encrypt_core.sv
// Top level of the AES-128 block encrypt core: key registers and the chain of round cells.
//
// Usage:
//  - req channel: one 128-bit plaintext block per transfer (req_valid/req_ready).
//  - rsp channel: one 128-bit ciphertext block per request, in request order.
//  - csr channel: csr_index 0 writes key_high, 1 writes key_low; csr_ready is always high.
//    A block uses the key held at the cycle it is transferred in; each block carries
//    its own key down the chain and the schedule is expanded on the fly, one round
//    key per cell, so a new key applies from the next transfer on.
//  - Path: one registered cell per round; rsp_valid rises once a transferred block
//    has passed through all 10 cells.
//  - Throughput: one block per cycle while rsp_ready stays high.
//  - Stall: each cell holds its block while its successor is full; empty cells keep
//    taking data, so req_ready drops only once all 10 cells hold blocks and
//    rsp_ready is low.
//  - Reset: all cells empty, both key halves cleared to zero.
module aes128_block_encrypt_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  aes128_pkg::aes128_req_type                req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output aes128_pkg::aes128_rsp_type                rsp_data,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [aes128_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [63:0]                               csr_data
);

   logic [63:0] key_high_ff, key_high_in;
   logic [63:0] key_low_ff,  key_low_in;

   logic                         stage_valid [aes128_pkg::ROUND_COUNT+1];
   logic                         stage_ready [aes128_pkg::ROUND_COUNT+1];
   aes128_pkg::aes128_stage_type stage_data  [aes128_pkg::ROUND_COUNT+1];

   assign csr_ready = 1'b1;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_valid) begin
         unique case (aes128_pkg::aes128_csr_index_type'(csr_index))
            aes128_pkg::CSR_KEY_HIGH: key_high_in = csr_data;
            aes128_pkg::CSR_KEY_LOW:  key_low_in  = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   // initial key addition in front of the first cell
   assign stage_valid[0]          = req_valid;
   assign req_ready               = stage_ready[0];
   assign stage_data[0].round_key = {key_high_ff, key_low_ff};
   assign stage_data[0].state     = {req_data.plain_high, req_data.plain_low}
                                    ^ {key_high_ff, key_low_ff};

   for (genvar i = 0; i < aes128_pkg::ROUND_COUNT; i++) begin : g_round
      aes128_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .rcon       (aes128_pkg::RCON[i]),
         .last_round (i == aes128_pkg::ROUND_COUNT - 1),
         .up_valid   (stage_valid[i]),
         .up_ready   (stage_ready[i]),
         .up_data    (stage_data[i]),
         .dn_valid   (stage_valid[i+1]),
         .dn_ready   (stage_ready[i+1]),
         .dn_data    (stage_data[i+1])
      );
   end

   assign rsp_valid                       = stage_valid[aes128_pkg::ROUND_COUNT];
   assign stage_ready[aes128_pkg::ROUND_COUNT] = rsp_ready;
   assign rsp_data.cipher_high = stage_data[aes128_pkg::ROUND_COUNT].state[127:64];
   assign rsp_data.cipher_low  = stage_data[aes128_pkg::ROUND_COUNT].state[63:0];

   // back-pressure at the input only comes from a stalled, full output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without an output stall");

   // a transfer lands in the first cell
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> stage_valid[1])
      else $error("accepted block lost at first round cell");

   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

// File: design/aes128_round_cell.sv
// One AES round cell: expands its round key and applies one round to the state.
module aes128_round_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 rcon,
   input  logic                       last_round,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  aes128_pkg::aes128_stage_type up_data,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output aes128_pkg::aes128_stage_type dn_data
);

   logic                         valid_ff, valid_in;
   aes128_pkg::aes128_stage_type stage_ff, stage_in;
   logic [127:0]                 key_next;
   logic [127:0]                 shifted;

   // an empty cell always takes a transfer, so bubbles close up
   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      key_next = aes128_pkg::next_key(up_data.round_key, rcon);
      shifted  = aes128_pkg::sub_shift(up_data.state);
      valid_in = up_ready ? up_valid : valid_ff;
      stage_in.round_key = key_next;
      if (last_round) begin
         stage_in.state = shifted ^ key_next;
      end else begin
         stage_in.state = aes128_pkg::mix_columns(shifted) ^ key_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = stage_ff;

endmodule
